// ===== rtl/rcnm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnm_pkg
// Shared types and constants of the raster cross-neighbor max/min core.
// ----------------------------------------------------------------------------
package rcnm_pkg;

  // Fixed field widths.
  localparam int COORD_W   = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int MAX_ROWS  = 1024;

  // Defaults of the top-level parameters.
  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_PIXEL_BITS = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_ROWS = 1'b0,
    REG_FRAME_COLS = 1'b1
  } cfg_reg_e;

  // Which of the four cross neighbors take part in a result.
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } nb_mask_t;

  // Status flags of one result.
  typedef struct packed {
    logic has_neighbor;
    logic is_local_min;
  } nb_flags_t;

endpackage

// ===== rtl/raster_cross_neighbor_max_min_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_cross_neighbor_max_min_core
// Four-neighbor max/min filter with local-minimum flag on a raster stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per cycle while s_axis_tready is high. Each
// accepted pixel is written to a two-line store and, in the same cycle, the
// store is read at two addresses: the pixel two rows up and the pixel up and
// to the right. Those reads feed a short chain of window cells that shift
// once per accepted pixel, so the results for the row above come out one
// line behind the input, through the pixel stage and the output register,
// one result per cycle unless the output stalls. On the last row of the
// frame a pixel also releases results of its own row (up to three in all),
// and the input waits while the port sends the rest, one result per cycle.
// A register write restarts the frame; write only while the core is idle.
// The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module raster_cross_neighbor_max_min_core
  import rcnm_pkg::*;
#(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  localparam int IN_W      = ((PIXEL_BITS + 7) / 8) * 8,
  localparam int OUT_RAW   = 2 * COORD_W + 3 * PIXEL_BITS + 2,
  localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // Pixel requests.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,  // pixel_in
  // Result requests.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_row, out_col, out_value, neighbor_max, neighbor_min, has_neighbor,
  // is_local_min
  output logic [OUT_W-1:0]     m_axis_tdata,
  output logic                 m_axis_tlast,  // last_in_run
  output logic [0:0]           m_axis_tuser   // end_of_frame
);

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ADDR_W = COL_W + 1;
  localparam int CMP_W  = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

  typedef logic signed [PIXEL_BITS-1:0] pix_t;

  // Configuration, kept as last row and last column indexes.
  logic [COORD_W-1:0] rows_last_q, rows_last_d;
  logic [COL_W-1:0]   cols_last_q, cols_last_d;

  // Position of the next pixel.
  logic [COORD_W-1:0] row_q;
  logic [COL_W-1:0]   col_q;
  logic               last_c;
  logic               last_r;

  // Handshake.
  logic in_acc;
  logic in_ready;

  // Stage holding the most recent accepted pixel.
  pix_t               px1_q;
  logic [COORD_W-1:0] row1_q;
  logic [COL_W-1:0]   col1_q;
  logic               up_vld1_q;
  logic               rgt_vld1_q;
  logic               byp_q;
  logic [2:0]         pend_q, pend_d;
  logic [2:0]         pend_new;

  // Store.
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_a_addr;
  logic [PIXEL_BITS-1:0] rd_a_raw;
  logic [PIXEL_BITS-1:0] rd_b_raw;
  pix_t                  rd_a_data;
  pix_t                  rd_b_data;

  // Window cells: row above at columns c and c-1, this row at c-1 and c-2.
  pix_t a0_val, am1_val, m1_val, m2_val;
  logic a0_vld, am1_vld, m1_vld, m2_vld;
  pix_t a0_in;
  logic col_nz;

  // Results.
  pix_t      r1_max, r1_min, r2_max, r2_min, r3_max, r3_min;
  nb_flags_t r1_flags, r2_flags, r3_flags;
  nb_mask_t  r1_mask, r2_mask, r3_mask;

  // Output register.
  logic               out_load;
  logic [2:0]         sel_bit;
  logic [2:0]         pend_rest;
  logic               out_valid_q;
  logic [COORD_W-1:0] o_row_q, o_row_d;
  logic [COORD_W-1:0] o_col_q, o_col_d;
  pix_t               o_val_q, o_val_d;
  pix_t               o_max_q, o_max_d;
  pix_t               o_min_q, o_min_d;
  nb_flags_t          o_flags_q, o_flags_d;
  logic               o_last_q;
  logic               o_eof_q, o_eof_d;

  // --------------------------------------------------------------------------
  // Configuration: clamp the frame size once, at the write.
  // --------------------------------------------------------------------------
  always_comb begin
    if (cfg_wdata_i == '0) begin
      rows_last_d = '0;
    end else if (cfg_wdata_i >= CFG_W'(MAX_ROWS)) begin
      rows_last_d = COORD_W'(MAX_ROWS - 1);
    end else begin
      rows_last_d = COORD_W'(cfg_wdata_i - CFG_W'(1));
    end
    if (cfg_wdata_i == '0) begin
      cols_last_d = '0;
    end else if (CMP_W'(cfg_wdata_i) >= CMP_W'(MAX_COLS)) begin
      cols_last_d = COL_W'(MAX_COLS - 1);
    end else begin
      cols_last_d = COL_W'(cfg_wdata_i - CFG_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_last_q <= '0;
      cols_last_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_ROWS: rows_last_q <= rows_last_d;
        REG_FRAME_COLS: cols_last_q <= cols_last_d;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Raster position.
  // --------------------------------------------------------------------------
  assign last_c = (col_q == cols_last_q);
  assign last_r = (row_q == rows_last_q);
  assign col_nz = (col_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_we_i) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      if (last_c) begin
        col_q <= '0;
        row_q <= last_r ? '0 : row_q + COORD_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line store. Bank is the row parity. At the end of a row, port A fetches
  // the start of this row so the next row sees it as its first upper pixel.
  // --------------------------------------------------------------------------
  assign wr_addr   = {row_q[0], col_q};
  assign rd_a_addr = last_c ? {row_q[0], COL_W'(0)} : {~row_q[0], col_q + COL_W'(1)};

  rcnm_line_mem #(
    .DATA_W (PIXEL_BITS),
    .ADDR_W (ADDR_W)
  ) u_line_mem (
    .clk_i     (clk_i),
    .we_i      (in_acc),
    .waddr_i   (wr_addr),
    .wdata_i   (s_axis_tdata[PIXEL_BITS-1:0]),
    .re_i      (in_acc),
    .raddr_a_i (rd_a_addr),
    .raddr_b_i (wr_addr),
    .rdata_a_o (rd_a_raw),
    .rdata_b_o (rd_b_raw)
  );

  assign rd_a_data = pix_t'(rd_a_raw);
  assign rd_b_data = pix_t'(rd_b_raw);

  // --------------------------------------------------------------------------
  // Pixel stage.
  // --------------------------------------------------------------------------
  assign pend_new = {last_r && last_c, last_r && col_nz, row_q != '0};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px1_q      <= pix_t'(s_axis_tdata[PIXEL_BITS-1:0]);
      row1_q     <= row_q;
      col1_q     <= col_q;
      up_vld1_q  <= (row_q > COORD_W'(1));
      rgt_vld1_q <= (row_q != '0) && !last_c;
    end
  end

  // With one column the row start was just written, so it is taken from
  // the stage register instead of the store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (in_acc) begin
      byp_q <= last_c && !col_nz;
    end
  end

  assign a0_in = byp_q ? px1_q : rd_a_data;

  rcnm_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell_a0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (in_acc),
    .keep_i  (1'b1),
    .val_i   (a0_in),
    .vld_i   (row_q != '0),
    .val_o   (a0_val),
    .vld_o   (a0_vld)
  );

  rcnm_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell_am1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (in_acc),
    .keep_i  (col_nz),
    .val_i   (a0_val),
    .vld_i   (a0_vld),
    .val_o   (am1_val),
    .vld_o   (am1_vld)
  );

  rcnm_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell_m1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (in_acc),
    .keep_i  (col_nz),
    .val_i   (px1_q),
    .vld_i   (1'b1),
    .val_o   (m1_val),
    .vld_o   (m1_vld)
  );

  rcnm_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell_m2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (in_acc),
    .keep_i  (col_nz),
    .val_i   (m1_val),
    .vld_i   (m1_vld),
    .val_o   (m2_val),
    .vld_o   (m2_vld)
  );

  // --------------------------------------------------------------------------
  // The three possible results of the staged pixel: the pixel above it, the
  // pixel to its left on the last row, and the pixel itself at frame end.
  // --------------------------------------------------------------------------
  assign r1_mask = '{up: up_vld1_q, down: 1'b1, left: am1_vld, right: rgt_vld1_q};
  assign r2_mask = '{up: am1_vld, down: 1'b0, left: m2_vld, right: 1'b1};
  assign r3_mask = '{up: a0_vld, down: 1'b0, left: m1_vld, right: 1'b0};

  rcnm_result #(.PIXEL_BITS(PIXEL_BITS)) u_result_above (
    .centre_i (a0_val),
    .up_i     (rd_b_data),
    .down_i   (px1_q),
    .left_i   (am1_val),
    .right_i  (rd_a_data),
    .mask_i   (r1_mask),
    .max_o    (r1_max),
    .min_o    (r1_min),
    .flags_o  (r1_flags)
  );

  rcnm_result #(.PIXEL_BITS(PIXEL_BITS)) u_result_left (
    .centre_i (m1_val),
    .up_i     (am1_val),
    .down_i   (px1_q),
    .left_i   (m2_val),
    .right_i  (px1_q),
    .mask_i   (r2_mask),
    .max_o    (r2_max),
    .min_o    (r2_min),
    .flags_o  (r2_flags)
  );

  rcnm_result #(.PIXEL_BITS(PIXEL_BITS)) u_result_self (
    .centre_i (px1_q),
    .up_i     (a0_val),
    .down_i   (px1_q),
    .left_i   (m1_val),
    .right_i  (px1_q),
    .mask_i   (r3_mask),
    .max_o    (r3_max),
    .min_o    (r3_min),
    .flags_o  (r3_flags)
  );

  // --------------------------------------------------------------------------
  // Result selection, pending mask and input handshake.
  // --------------------------------------------------------------------------
  always_comb begin
    if (pend_q[0]) begin
      sel_bit   = 3'b001;
      o_row_d   = row1_q - COORD_W'(1);
      o_col_d   = COORD_W'(col1_q);
      o_val_d   = a0_val;
      o_max_d   = r1_max;
      o_min_d   = r1_min;
      o_flags_d = r1_flags;
      o_eof_d   = 1'b0;
    end else if (pend_q[1]) begin
      sel_bit   = 3'b010;
      o_row_d   = row1_q;
      o_col_d   = COORD_W'(col1_q - COL_W'(1));
      o_val_d   = m1_val;
      o_max_d   = r2_max;
      o_min_d   = r2_min;
      o_flags_d = r2_flags;
      o_eof_d   = 1'b0;
    end else begin
      sel_bit   = 3'b100;
      o_row_d   = row1_q;
      o_col_d   = COORD_W'(col1_q);
      o_val_d   = px1_q;
      o_max_d   = r3_max;
      o_min_d   = r3_min;
      o_flags_d = r3_flags;
      o_eof_d   = 1'b1;
    end
    pend_rest = pend_q & ~sel_bit;
    out_load  = (pend_q != '0) && (!out_valid_q || m_axis_tready);
    in_ready  = (pend_q == '0) || (out_load && (pend_rest == '0));
    in_acc    = s_axis_tvalid && in_ready;
    if (in_acc) begin
      pend_d = pend_new;
    end else if (out_load) begin
      pend_d = pend_rest;
    end else begin
      pend_d = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_row_q   <= o_row_d;
      o_col_q   <= o_col_d;
      o_val_q   <= o_val_d;
      o_max_q   <= o_max_d;
      o_min_q   <= o_min_d;
      o_flags_q <= o_flags_d;
      o_last_q  <= (pend_rest == '0);
      o_eof_q   <= o_eof_d;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({o_flags_q.is_local_min, o_flags_q.has_neighbor,
                                 o_min_q, o_max_q, o_val_q, o_col_q, o_row_q});
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tuser  = o_eof_q;

endmodule

// ===== rtl/rcnm_line_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnm_line_mem
// Two-line pixel store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rcnm_line_mem #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_a_q;
  logic [DATA_W-1:0] rdata_b_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/rcnm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnm_cell
// One tap of a pixel window: holds a pixel and its presence bit and takes
// its neighbor's contents on every shift.
// ----------------------------------------------------------------------------
module rcnm_cell #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  logic                         keep_i,
  input  logic signed [PIXEL_BITS-1:0] val_i,
  input  logic                         vld_i,
  output logic signed [PIXEL_BITS-1:0] val_o,
  output logic                         vld_o
);

  logic signed [PIXEL_BITS-1:0] val_q;
  logic                         vld_q;
  logic                         vld_d;

  // The presence bit drops on a shift with keep_i low, as when the window moves into a new row.
  assign vld_d = vld_i & keep_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= val_i;
    end
  end

  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule

// ===== rtl/rcnm_result.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcnm_result
// Maximum and minimum over the present cross neighbors of one pixel, with
// the local-minimum flag.
// ----------------------------------------------------------------------------
module rcnm_result
  import rcnm_pkg::*;
#(
  parameter int PIXEL_BITS = 16
) (
  input  logic signed [PIXEL_BITS-1:0] centre_i,
  input  logic signed [PIXEL_BITS-1:0] up_i,
  input  logic signed [PIXEL_BITS-1:0] down_i,
  input  logic signed [PIXEL_BITS-1:0] left_i,
  input  logic signed [PIXEL_BITS-1:0] right_i,
  input  nb_mask_t                     mask_i,
  output logic signed [PIXEL_BITS-1:0] max_o,
  output logic signed [PIXEL_BITS-1:0] min_o,
  output nb_flags_t                    flags_o
);

  localparam logic signed [PIXEL_BITS-1:0] PIX_LOW  = {1'b1, {(PIXEL_BITS-1){1'b0}}};
  localparam logic signed [PIXEL_BITS-1:0] PIX_HIGH = {1'b0, {(PIXEL_BITS-1){1'b1}}};

  logic signed [PIXEL_BITS-1:0] hi;
  logic signed [PIXEL_BITS-1:0] lo;

  always_comb begin
    hi = PIX_LOW;
    lo = PIX_HIGH;
    if (mask_i.up) begin
      if (up_i > hi) hi = up_i;
      if (up_i < lo) lo = up_i;
    end
    if (mask_i.down) begin
      if (down_i > hi) hi = down_i;
      if (down_i < lo) lo = down_i;
    end
    if (mask_i.left) begin
      if (left_i > hi) hi = left_i;
      if (left_i < lo) lo = left_i;
    end
    if (mask_i.right) begin
      if (right_i > hi) hi = right_i;
      if (right_i < lo) lo = right_i;
    end
  end

  assign max_o                = hi;
  assign min_o                = lo;
  assign flags_o.has_neighbor = |mask_i;
  assign flags_o.is_local_min = (lo >= centre_i);

endmodule
